// ----- rtl/core/l1l2_pkg.sv -----
`timescale 1ns / 1ps
package l1l2_pkg;
    localparam int unsigned PixW   = 8;
    localparam int unsigned SqW    = 16;
    localparam int unsigned SumW   = 17;
    localparam int unsigned NumW   = 24;
    localparam int unsigned QW     = 8;
    localparam int unsigned FullScale = 255;
    localparam int unsigned FifoDepthDefault = 4;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic [SqW-1:0]  d1;
        logic [SqW-1:0]  d2;
        logic [SqW-1:0]  d3;
        logic [SumW-1:0] s;
        logic            gray;
    } t_work;

    typedef struct packed {
        logic [QW-1:0] c1;
        logic [QW-1:0] c2;
        logic [QW-1:0] c3;
        logic          gray;
    } t_res;
endpackage

// ----- rtl/core/l1l2_if.sv -----
`timescale 1ns / 1ps
interface l1l2_pix_if;
    logic                        valid;
    logic                        ready;
    logic [l1l2_pkg::PixW-1:0]   red;
    logic [l1l2_pkg::PixW-1:0]   green;
    logic [l1l2_pkg::PixW-1:0]   blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface l1l2_res_if;
    logic                      valid;
    logic                      ready;
    logic [l1l2_pkg::QW-1:0]   comp_one;
    logic [l1l2_pkg::QW-1:0]   comp_two;
    logic [l1l2_pkg::QW-1:0]   comp_three;
    logic                      gray_pixel;
    modport source (output valid, comp_one, comp_two, comp_three, gray_pixel, input ready);
    modport sink   (input valid, comp_one, comp_two, comp_three, gray_pixel, output ready);
endinterface

// ----- rtl/core/l1l2_front.sv -----
`timescale 1ns / 1ps
// Squares the channel differences and classifies gray pixels; one register stage.
module l1l2_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    output logic             o_valid,
    input  logic             i_ready,
    output l1l2_pkg::t_work  o_work
);
    logic [7:0] ad1, ad2, ad3;
    l1l2_pkg::t_work n_work, r_work;
    logic r_valid;

    assign ad1 = (i_red > i_green) ? i_red - i_green : i_green - i_red;
    assign ad2 = (i_red > i_blue) ? i_red - i_blue : i_blue - i_red;
    assign ad3 = (i_green > i_blue) ? i_green - i_blue : i_blue - i_green;

    always_comb begin
        n_work.d1 = 16'(ad1) * 16'(ad1);
        n_work.d2 = 16'(ad2) * 16'(ad2);
        n_work.d3 = 16'(ad3) * 16'(ad3);
        n_work.s  = 17'(n_work.d1) + 17'(n_work.d2) + 17'(n_work.d3);
        n_work.gray = (i_red == i_green) && (i_green == i_blue);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end
endmodule

// ----- rtl/core/l1l2_fifo.sv -----
`timescale 1ns / 1ps
// Small queue between front and back.
module l1l2_fifo #(
    parameter int unsigned Depth = l1l2_pkg::FifoDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  l1l2_pkg::t_work i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output l1l2_pkg::t_work o_data
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    l1l2_pkg::t_work r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != (AW+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

// ----- rtl/core/l1l2_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: 255*d / s, one quotient bit per stage (8 stages).
// The quotient never exceeds 255 since d <= s.
module l1l2_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_d,
    input  logic [16:0] i_s,
    output logic [7:0]  o_q
);
    localparam int unsigned N = 8;
    logic [24:0] r_rem [N+1];
    logic [16:0] r_den [N+1];
    logic [7:0]  r_q   [N+1];
    logic [24:0] num;

    assign num = 25'({i_d, 8'd0}) - 25'(i_d);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num;
            r_den[0] <= i_s;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [25:0] sh;
        logic        take;
        assign sh   = 26'(r_den[k]) << (N-1-k);
        assign take = 26'(r_rem[k]) >= sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= take ? 25'(26'(r_rem[k]) - sh) : r_rem[k];
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= {r_q[k][6:0], take};
            end
        end
    end

    assign o_q = r_q[N];
endmodule

// ----- rtl/core/l1l2_back.sv -----
`timescale 1ns / 1ps
// Three dividers in lockstep; the pipeline advances only when its tail can move.
module l1l2_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  l1l2_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output l1l2_pkg::t_res  o_res
);
    localparam int unsigned Lat = 9;
    logic [Lat-1:0] r_vld;
    logic [Lat-1:0] r_gray;
    logic en;
    logic [7:0] q1, q2, q3;

    assign en      = !r_vld[Lat-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Lat-1];

    l1l2_div u_d1 (.i_clk, .i_en(en), .i_d(i_work.d1), .i_s(i_work.s), .o_q(q1));
    l1l2_div u_d2 (.i_clk, .i_en(en), .i_d(i_work.d2), .i_s(i_work.s), .o_q(q2));
    l1l2_div u_d3 (.i_clk, .i_en(en), .i_d(i_work.d3), .i_s(i_work.s), .o_q(q3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
        if (en) r_gray <= {r_gray[Lat-2:0], i_work.gray};
    end

    always_comb begin
        o_res.gray = r_gray[Lat-1];
        o_res.c1 = o_res.gray ? '0 : q1;
        o_res.c2 = o_res.gray ? '0 : q2;
        o_res.c3 = o_res.gray ? '0 : q3;
    end
endmodule

// ----- rtl/core/rgb_to_l1l2l3_color_invariant_core.sv -----
`timescale 1ns / 1ps
// l1l2l3 color-invariant core.
// Input channel i_pix (valid/ready) carries one 8-bit RGB pixel per transaction;
// output channel o_res carries comp_one..comp_three = floor(255*d/sum) and gray_pixel.
// A gray pixel (all channels equal) gives zero components and gray_pixel = 1.
// Throughput: one pixel per clock when the receiver keeps ready high.
// A pixel passes through 1 front register, the queue memory and 9 back stages (the
// 8-step pipelined dividers plus their load register).
// The front squares and classifies; a small queue decouples it from the divider
// pipeline, which freezes as a whole while the receiver stalls, with the result
// held stable. Synchronous active-low reset empties all stages; no transaction
// is lost or repeated across stalls.
module rgb_to_l1l2l3_color_invariant_core #(
    parameter int unsigned FifoDepth = l1l2_pkg::FifoDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    l1l2_pix_if.sink   i_pix,
    l1l2_res_if.source o_res
);
    l1l2_pkg::t_work fw, qw;
    l1l2_pkg::t_res  res;
    logic fv, fr, qv, qr;

    l1l2_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_pix.valid), .o_ready(i_pix.ready),
        .i_red(i_pix.red), .i_green(i_pix.green), .i_blue(i_pix.blue),
        .o_valid(fv), .i_ready(fr), .o_work(fw)
    );

    l1l2_fifo #(.Depth(FifoDepth)) u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(fv), .o_ready(fr), .i_data(fw),
        .o_valid(qv), .i_ready(qr), .o_data(qw)
    );

    l1l2_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(qv), .o_ready(qr), .i_work(qw),
        .o_valid(o_res.valid), .i_ready(o_res.ready), .o_res(res)
    );

    assign o_res.comp_one   = res.c1;
    assign o_res.comp_two   = res.c2;
    assign o_res.comp_three = res.c3;
    assign o_res.gray_pixel = res.gray;
endmodule
